// ===== rtl/quadratic_probe_symbol_table_top_assert.svh =====
`ifndef QUADRATIC_PROBE_SYMBOL_TABLE_TOP_ASSERT_SVH
`define QUADRATIC_PROBE_SYMBOL_TABLE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define QPST_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define QPST_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/qpst_pkg.sv =====
package qpst_pkg;
  localparam int TableSize = 64;
  localparam int MaxKeyLen = 32;
  localparam int ValueWidth = 32;
  localparam int SlotW = $clog2(TableSize);
  localparam int CharW = $clog2(MaxKeyLen);
  localparam int LenW = $clog2(MaxKeyLen + 2);
  localparam int KeyAddrW = SlotW + CharW;
  localparam logic [63:0] HashSeed = 64'd7;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0, ST_DUPLICATE = 3'd1, ST_FULL = 3'd2,
    ST_FOUND = 3'd3, ST_NOT_FOUND = 3'd4, ST_TOO_LONG = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_CMPWAIT, S_CMP, S_WRITE, S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept_char;   // fold in one character
    logic clear_key;     // reset hash and length
    logic start_probe;   // probe counter to zero, latch home
    logic next_probe;
    logic read_slot;     // read slot meta at probe address
    logic cmp_start;
    logic cmp_next;
    logic write_key;     // copy one char to table
    logic write_meta;
    logic set_result;
    status_e res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic too_long;
    logic occupied;
    logic len_match;
    logic cmp_done;
    logic cmp_equal;
    logic probes_done;
    logic copy_done;
  } stat_t;
endpackage

// ===== rtl/qpst_ctrl.sv =====
module qpst_ctrl import qpst_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic   opcode_i,
  input  logic   last_char_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  input  stat_t  stat_i,
  output cmd_t   cmd_o
);
  state_e state_q, state_d;
  logic op_q, op_d;
  logic out_valid_q, out_valid_d;
  logic acc;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && last_char_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    case (state_q)
      S_IDLE: begin
        if (acc && last_char_i) begin
          op_d = opcode_i;
          state_d = stat_i.too_long ? S_DONE : S_PROBE;
        end
      end
      S_PROBE: state_d = stat_i.probes_done ? S_DONE : S_CMPWAIT;
      S_CMPWAIT: begin
        if (!stat_i.occupied) state_d = op_q ? S_DONE : S_WRITE;
        else if (!stat_i.len_match) state_d = S_PROBE;
        else state_d = S_CMP;
      end
      S_CMP: begin
        if (stat_i.cmp_done) state_d = stat_i.cmp_equal ? S_DONE : S_PROBE;
      end
      S_WRITE: if (stat_i.copy_done) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = ST_NOT_FOUND;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept_char = acc;
        cmd_o.start_probe = acc && last_char_i;
        if (acc && last_char_i && stat_i.too_long) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_TOO_LONG;
        end
      end
      S_PROBE: begin
        cmd_o.read_slot = !stat_i.probes_done;
        if (stat_i.probes_done) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = op_q ? ST_NOT_FOUND : ST_FULL;
        end
      end
      S_CMPWAIT: begin
        cmd_o.cmp_start = 1'b1;
        if (!stat_i.occupied && op_q) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
        end
        if (stat_i.occupied && !stat_i.len_match) cmd_o.next_probe = 1'b1;
      end
      S_CMP: begin
        cmd_o.cmp_next = 1'b1;
        if (stat_i.cmp_done && stat_i.cmp_equal) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = op_q ? ST_FOUND : ST_DUPLICATE;
        end
        if (stat_i.cmp_done && !stat_i.cmp_equal) cmd_o.next_probe = 1'b1;
      end
      S_WRITE: begin
        cmd_o.write_key = 1'b1;
        if (stat_i.copy_done) begin
          cmd_o.write_meta = 1'b1;
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_INSERTED;
        end
      end
      S_DONE: begin
        cmd_o.clear_key = 1'b1;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ===== rtl/qpst_dp.sv =====
module qpst_dp import qpst_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            key_char_i,
  input  logic [31:0]           entry_value_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  output logic [2:0]            status_o,
  output logic [5:0]            slot_index_o,
  output logic [31:0]           found_value_o
);
  logic [63:0] hash_q;
  logic [LenW-1:0] len_q;
  logic [7:0] ibuf_q [MaxKeyLen];
  logic [TableSize-1:0] occ_q;
  logic [7:0] kmem [TableSize*MaxKeyLen];
  logic [LenW-1:0] lmem [TableSize];
  logic [ValueWidth-1:0] vmem [TableSize];
  logic [SlotW-1:0] home_q, slot_q;
  logic [SlotW:0] i_q;
  logic [SlotW-1:0] step_q;      // i*i mod size, kept incrementally
  logic [CharW:0] c_q;
  logic [LenW-1:0] rlen_q;
  logic [ValueWidth-1:0] rval_q, val_q;
  logic [7:0] rchar_q;
  logic rocc_q, rd_valid_q, eq_q;
  logic [2:0] st_q;
  logic [5:0] si_q;
  logic [31:0] fv_q;
  logic [63:0] hash_n;
  logic [LenW-1:0] len_n;
  logic [SlotW-1:0] pslot;
  logic [KeyAddrW-1:0] kaddr;

  assign hash_n = (hash_q << 5) + hash_q + {56'd0, key_char_i};
  assign len_n = (len_q <= LenW'(MaxKeyLen)) ? len_q + 1'b1 : len_q;
  assign pslot = home_q + step_q;
  assign kaddr = {slot_q, c_q[CharW-1:0]};

  assign stat_o.too_long = len_n > LenW'(MaxKeyLen);
  assign stat_o.occupied = rocc_q;
  assign stat_o.len_match = rlen_q == len_q;
  assign stat_o.cmp_done = rd_valid_q && (c_q == (CharW+1)'(len_q));
  assign stat_o.cmp_equal = eq_q;
  assign stat_o.probes_done = i_q == (SlotW+1)'(TableSize);
  assign stat_o.copy_done = c_q == (CharW+1)'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashSeed;
      len_q <= '0;
      occ_q <= '0;
    end else begin
      if (cmd_i.clear_key) begin
        hash_q <= HashSeed;
        len_q <= '0;
      end else if (cmd_i.accept_char) begin
        hash_q <= hash_n;
        len_q <= len_n;
      end
      if (cmd_i.write_meta) occ_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_char) begin
      if (len_q < LenW'(MaxKeyLen)) ibuf_q[len_q[CharW-1:0]] <= key_char_i;
      val_q <= entry_value_i[ValueWidth-1:0];
    end
    if (cmd_i.start_probe) begin
      home_q <= hash_n[SlotW-1:0];
      i_q <= '0;
      step_q <= '0;
    end else if (cmd_i.next_probe) begin
      // (i+1)^2 = i^2 + 2i + 1
      step_q <= step_q + {i_q[SlotW-2:0], 1'b1};
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.read_slot) begin
      slot_q <= pslot;
      rocc_q <= occ_q[pslot];
      rlen_q <= lmem[pslot];
      rval_q <= vmem[pslot];
      c_q <= '0;
      rd_valid_q <= 1'b0;
      eq_q <= 1'b1;
    end
    if (cmd_i.cmp_start) begin
      rchar_q <= kmem[kaddr];
      rd_valid_q <= 1'b0;
      c_q <= '0;
      eq_q <= 1'b1;
    end
    if (cmd_i.cmp_next && !stat_o.cmp_done) begin
      // compare one stored character per cycle
      eq_q <= eq_q && (rchar_q == ibuf_q[c_q[CharW-1:0]]);
      c_q <= c_q + 1'b1;
      rchar_q <= kmem[{slot_q, c_q[CharW-1:0] + 1'b1}];
      rd_valid_q <= 1'b1;
    end
    if (cmd_i.cmp_next && c_q == (CharW+1)'(len_q)) rd_valid_q <= 1'b1;
    if (cmd_i.write_key && !stat_o.copy_done) begin
      kmem[kaddr] <= ibuf_q[c_q[CharW-1:0]];
      c_q <= c_q + 1'b1;
    end
    if (cmd_i.write_meta) begin
      lmem[slot_q] <= len_q;
      vmem[slot_q] <= val_q;
    end
    if (cmd_i.set_result) begin
      st_q <= cmd_i.res_status;
      si_q <= '0;
      fv_q <= '0;
      if (cmd_i.res_status == ST_INSERTED || cmd_i.res_status == ST_FOUND)
        si_q <= 6'(slot_q);
      if (cmd_i.res_status == ST_FOUND) fv_q <= 32'(rval_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_key) begin
      status_o <= st_q;
      slot_index_o <= si_q;
      found_value_o <= fv_q;
    end
  end
endmodule

// ===== rtl/quadratic_probe_symbol_table_top.sv =====
// an ordinary character is folded into hash and length and gives no result
// final character: each probe reads a slot; free ends the search, other length probes on,
// equal length compares keys; insert copies the key; full table or too long key ends it
// one character per cycle while idle; final character blocks input until its word is out
// rst_ni asynchronous active low: table empty, hash 7, key length zero
// table contents are not cleared by reset, only the occupied bits
module quadratic_probe_symbol_table_top import qpst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  key_char_i,
  input  logic        last_char_i,
  input  logic [31:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_index_o,
  output logic [31:0] found_value_o
);
  `include "quadratic_probe_symbol_table_top_assert.svh"
  cmd_t cmd;
  stat_t stat;

  qpst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .last_char_i,
    .out_valid_o, .out_stall_i, .stat_i(stat), .cmd_o(cmd)
  );

  qpst_dp u_dp (
    .clk_i, .rst_ni, .key_char_i, .entry_value_i, .cmd_i(cmd), .stat_o(stat),
    .status_o, .slot_index_o, .found_value_o
  );

  `QPST_ASSERT_NXT(a_done_valid, clk_i, rst_ni, cmd.clear_key, out_valid_o)
  `QPST_ASSERT_IMP(a_wr_ins, clk_i, rst_ni, cmd.write_meta,
    cmd.set_result && cmd.res_status == ST_INSERTED)
  `QPST_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, cmd.read_slot, in_stall_o)
endmodule
